@@ hdl/tcpd_pkg.sv @@
// Shared constants and types for the text command pin driver.
// Used by tcpd_parse, tcpd_resolve, text_command_pin_driver and the testbench; depends on nothing else.
package tcpd_pkg;

   localparam int PinCountDefault = 32;

   // Widths of the item fields.
   localparam int CharWidth   = 8;
   localparam int WordWidth   = 32;
   localparam int StatusWidth = 2;
   localparam int IndexWidth  = 8;
   localparam int ReqDataWidth = CharWidth + 3 * WordWidth;
   localparam int RspDataWidth = 48;

   // Parser modes.
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_LOW  = 2'd1;
   localparam logic [1:0] MODE_HIGH = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_NONE     = 2'd0;
   localparam logic [1:0] STATUS_SET      = 2'd1;
   localparam logic [1:0] STATUS_DISABLED = 2'd2;
   localparam logic [1:0] STATUS_INVALID  = 2'd3;

   // Command characters.
   localparam logic [7:0] CHAR_W_LOWER = 8'h77;
   localparam logic [7:0] CHAR_W_UPPER = 8'h57;
   localparam logic [7:0] CHAR_L_LOWER = 8'h6c;
   localparam logic [7:0] CHAR_L_UPPER = 8'h4c;
   localparam logic [7:0] CHAR_H_LOWER = 8'h68;
   localparam logic [7:0] CHAR_H_UPPER = 8'h48;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [11:0] RADIX       = 12'd10;
   localparam logic [7:0] INDEX_MAX    = 8'hff;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [IndexWidth-1:0]  status_pin;
   } tcpd_report_type;

endpackage

@@ hdl/tcpd_parse.sv @@
// Command character parser and per-pin level and weak registers.
// Depends on tcpd_pkg; instantiated by text_command_pin_driver.
module tcpd_parse import tcpd_pkg::*; #(
   parameter int PIN_COUNT = PinCountDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  cmd,
   input  logic [CharWidth-1:0]  char_code,
   input  logic                  last_in_chunk,
   input  logic [WordWidth-1:0]  pin_output_enable,
   output logic [PIN_COUNT-1:0]  levels_in,
   output logic [PIN_COUNT-1:0]  weak_in,
   output tcpd_report_type       report
);

   logic [PIN_COUNT-1:0]  levels_ff;
   logic [PIN_COUNT-1:0]  weak_ff;
   logic                  armed_ff, armed_in;
   logic [1:0]            mode_ff, mode_in;
   logic [IndexWidth-1:0] acc_ff, acc_in;

   logic                  pending;
   logic                  is_digit;
   logic [11:0]           acc_sum;
   logic [IndexWidth-1:0] acc_step;
   logic [1:0]            mode_mid;
   logic [IndexWidth-1:0] acc_mid;
   logic                  armed_mid;
   logic                  fin_char;
   logic                  fin_chunk;
   logic                  fin;
   logic                  fin_high;
   logic [IndexWidth-1:0] fin_idx;
   logic                  fin_valid;
   logic [CharWidth-1:0]  digit;

   assign pending  = (mode_ff == MODE_LOW) || (mode_ff == MODE_HIGH);
   assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign digit    = char_code - CHAR_ZERO;
   assign acc_sum  = {4'd0, acc_ff} * RADIX + {8'd0, digit[3:0]};
   assign acc_step = (acc_sum > {4'd0, INDEX_MAX}) ? INDEX_MAX : acc_sum[IndexWidth-1:0];

   // Effect of the character itself, before the chunk end is applied.
   always_comb begin
      mode_mid  = mode_ff;
      acc_mid   = acc_ff;
      armed_mid = armed_ff;
      fin_char  = 1'b0;
      if (pending) begin
         if (is_digit) begin
            acc_mid = acc_step;
         end else begin
            fin_char = 1'b1;
         end
      end else begin
         mode_mid = MODE_IDLE;
         if (char_code == CHAR_W_LOWER || char_code == CHAR_W_UPPER) begin
            armed_mid = 1'b1;
         end else if (char_code == CHAR_L_LOWER || char_code == CHAR_L_UPPER) begin
            mode_mid = MODE_LOW;
            acc_mid  = '0;
         end else if (char_code == CHAR_H_LOWER || char_code == CHAR_H_UPPER) begin
            mode_mid = MODE_HIGH;
            acc_mid  = '0;
         end
      end
   end

   // A chunk end completes a number that is still open after the character.
   assign fin_chunk = last_in_chunk && !fin_char &&
                      ((mode_mid == MODE_LOW) || (mode_mid == MODE_HIGH));
   assign fin       = !cmd && (fin_char || fin_chunk);
   assign fin_high  = fin_char ? (mode_ff == MODE_HIGH) : (mode_mid == MODE_HIGH);
   assign fin_idx   = fin_char ? acc_ff : acc_mid;
   assign fin_valid = {24'd0, fin_idx} < 32'(PIN_COUNT);

   always_comb begin
      levels_in = levels_ff;
      weak_in   = weak_ff;
      for (int i = 0; i < PIN_COUNT; i++) begin
         if (fin && fin_valid && fin_idx == 8'(i)) begin
            levels_in[i] = fin_high;
            weak_in[i]   = armed_ff;
         end
      end
   end

   always_comb begin
      report.status     = STATUS_NONE;
      report.status_pin = '0;
      if (fin) begin
         report.status_pin = fin_idx;
         if (!fin_valid) begin
            report.status = STATUS_INVALID;
         end else if (pin_output_enable[fin_idx[4:0]]) begin
            report.status = STATUS_SET;
         end else begin
            report.status = STATUS_DISABLED;
         end
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      armed_in = armed_ff;
      if (!cmd) begin
         if (fin || last_in_chunk) begin
            mode_in  = MODE_IDLE;
            acc_in   = '0;
            armed_in = 1'b0;
         end else begin
            mode_in  = mode_mid;
            acc_in   = acc_mid;
            armed_in = armed_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= '0;
         weak_ff   <= '0;
         armed_ff  <= 1'b0;
         mode_ff   <= MODE_IDLE;
         acc_ff    <= '0;
      end else if (step) begin
         levels_ff <= levels_in;
         weak_ff   <= weak_in;
         armed_ff  <= armed_in;
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
      end
   end

endmodule

@@ hdl/tcpd_resolve.sv @@
// Resolves host-driven pin levels against the pad pulls of weak pins.
// Depends on tcpd_pkg; instantiated by text_command_pin_driver.
module tcpd_resolve import tcpd_pkg::*; #(
   parameter int PIN_COUNT = PinCountDefault
) (
   input  logic [PIN_COUNT-1:0] levels,
   input  logic [PIN_COUNT-1:0] weak_mask,
   input  logic [WordWidth-1:0] pull_enable,
   input  logic [WordWidth-1:0] pull_select,
   output logic [WordWidth-1:0] pin_levels
);

   for (genvar i = 0; i < WordWidth; i++) begin : g_pin
      if (i < PIN_COUNT) begin : g_used
         // A weak pin with its pull enabled follows the pull direction.
         assign pin_levels[i] = (weak_mask[i] && pull_enable[i]) ? pull_select[i] : levels[i];
      end else begin : g_unused
         assign pin_levels[i] = 1'b0;
      end
   end

endmodule

@@ hdl/text_command_pin_driver.sv @@
// Text command pin driver: input register, parser with pin state, output register.
// Depends on tcpd_pkg, tcpd_parse and tcpd_resolve.
//
// Usage:
//   The req channel carries one item per transfer: tuser is the kind (0 command
//   character, 1 tick that only samples the pins), tlast marks the end of a read
//   chunk, and tdata holds the character and the three pad words.
//   The rsp channel returns exactly one result per item, in order: the resolved
//   pin levels, a status code and the pin index of a command that completed.
//   rsp_tvalid rises once the item has passed the input register: the item is first
//   held in the input register, then the parse and pin update write the output
//   register, from which the rsp transfer is made.
//   Throughput is one item per cycle while the receiver does not stall; the parser
//   state, the per-pin levels and the weak flags are read-modify-write registers.
//   When the receiver stalls, the result holds in the output register and one
//   more item may wait in the input register; req_tready then drops.
//   Reset clears all pin levels, weak flags, the armed weak mode and the parser,
//   and empties both registers.
module text_command_pin_driver import tcpd_pkg::*; #(
   parameter int PIN_COUNT = PinCountDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // char_code [7:0], pin_output_enable [39:8], pull_enable [71:40],
   // pull_select [103:72]
   input  logic [ReqDataWidth-1:0] req_tdata,
   // cmd
   input  logic                    req_tuser,
   // last_in_chunk
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // pin_levels [31:0], status [33:32], status_pin [41:34], zero [47:42]
   output logic [RspDataWidth-1:0] rsp_tdata
);

   logic                    hold_valid_ff;
   logic                    hold_cmd_ff;
   logic                    hold_last_ff;
   logic [ReqDataWidth-1:0] hold_data_ff;
   logic                    rsp_valid_ff;
   logic [RspDataWidth-1:0] rsp_data_ff;
   logic [RspDataWidth-1:0] rsp_data_in;

   logic                    advance;
   logic [PIN_COUNT-1:0]    levels_in;
   logic [PIN_COUNT-1:0]    weak_in;
   tcpd_report_type         report;
   logic [WordWidth-1:0]    pin_levels;

   // The held item moves on when the output register is empty or being taken.
   assign advance    = hold_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !hold_valid_ff || advance;

   tcpd_parse #(
      .PIN_COUNT(PIN_COUNT)
   ) u_parse (
      .clock             (clock),
      .reset             (reset),
      .step              (advance),
      .cmd               (hold_cmd_ff),
      .char_code         (hold_data_ff[7:0]),
      .last_in_chunk     (hold_last_ff),
      .pin_output_enable (hold_data_ff[39:8]),
      .levels_in         (levels_in),
      .weak_in           (weak_in),
      .report            (report)
   );

   tcpd_resolve #(
      .PIN_COUNT(PIN_COUNT)
   ) u_resolve (
      .levels      (levels_in),
      .weak_mask   (weak_in),
      .pull_enable (hold_data_ff[71:40]),
      .pull_select (hold_data_ff[103:72]),
      .pin_levels  (pin_levels)
   );

   assign rsp_data_in = {6'd0, report.status_pin, report.status, pin_levels};

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_tready) begin
         hold_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         hold_cmd_ff  <= req_tuser;
         hold_last_ff <= req_tlast;
         hold_data_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ test/tb_text_command_pin_driver.sv @@
// Self-checking testbench for text_command_pin_driver: directed and random command text.
// A scoreboard class predicts every result; it depends on tcpd_pkg and the block's RTL.
module tb_text_command_pin_driver;
   import tcpd_pkg::*;

   localparam int PinCount = PinCountDefault;

   typedef struct {
      logic [WordWidth-1:0]   pin_levels;
      logic [StatusWidth-1:0] status;
      logic [IndexWidth-1:0]  status_pin;
   } pin_result_type;

   // Tracks the driver's pin registers and parser, and holds the results still due.
   class pin_bank;
      logic [WordWidth-1:0]  driven_levels;
      logic [WordWidth-1:0]  weak_flags;
      bit                    weak_armed;
      logic [1:0]            mode;
      logic [IndexWidth-1:0] index_accum;
      pin_result_type        levels_due[$];
      int unsigned           mismatch_count;

      function new();
         driven_levels  = '0;
         weak_flags     = '0;
         weak_armed     = 1'b0;
         mode           = MODE_IDLE;
         index_accum    = '0;
         mismatch_count = 0;
      endfunction

      function int unsigned pending();
         return levels_due.size();
      endfunction

      function void complete_command(input logic [WordWidth-1:0] oe,
                                     output logic [StatusWidth-1:0] status,
                                     output logic [IndexWidth-1:0] status_pin);
         logic [WordWidth-1:0] pin_mask;
         status_pin = index_accum;
         if (index_accum < PinCount) begin
            pin_mask = 32'd1 << index_accum;
            if (mode == MODE_HIGH) driven_levels = driven_levels | pin_mask;
            else driven_levels = driven_levels & ~pin_mask;
            if (weak_armed) weak_flags = weak_flags | pin_mask;
            else weak_flags = weak_flags & ~pin_mask;
            status = ((oe & pin_mask) != 0) ? STATUS_SET : STATUS_DISABLED;
         end else begin
            status = STATUS_INVALID;
         end
         weak_armed  = 1'b0;
         mode        = MODE_IDLE;
         index_accum = '0;
      endfunction

      function void note_item(input bit tick, input logic [CharWidth-1:0] ch, input bit last,
                              input logic [WordWidth-1:0] oe, input logic [WordWidth-1:0] pen,
                              input logic [WordWidth-1:0] psel);
         logic [StatusWidth-1:0] status;
         logic [IndexWidth-1:0]  status_pin;
         logic [WordWidth-1:0]   weak_pull;
         int unsigned            next_index;
         pin_result_type         result;
         status     = STATUS_NONE;
         status_pin = '0;
         if (!tick) begin
            if (mode == MODE_LOW || mode == MODE_HIGH) begin
               if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                  next_index = int'(index_accum) * int'(RADIX) + int'(ch - CHAR_ZERO);
                  index_accum = (next_index > INDEX_MAX) ? INDEX_MAX : next_index[7:0];
               end else begin
                  // Any non-digit ends the number and is swallowed.
                  complete_command(oe, status, status_pin);
               end
            end else begin
               mode = MODE_IDLE;
               case (ch)
                  CHAR_W_LOWER, CHAR_W_UPPER: weak_armed = 1'b1;
                  CHAR_L_LOWER, CHAR_L_UPPER: begin
                     mode        = MODE_LOW;
                     index_accum = '0;
                  end
                  CHAR_H_LOWER, CHAR_H_UPPER: begin
                     mode        = MODE_HIGH;
                     index_accum = '0;
                  end
                  default: ;
               endcase
            end
            if (last) begin
               if (mode == MODE_LOW || mode == MODE_HIGH)
                  complete_command(oe, status, status_pin);
               weak_armed  = 1'b0;
               mode        = MODE_IDLE;
               index_accum = '0;
            end
         end
         weak_pull         = weak_flags & pen;
         result.pin_levels = (driven_levels & ~weak_pull) | (weak_pull & psel);
         result.status     = status;
         result.status_pin = status_pin;
         levels_due.push_back(result);
      endfunction

      function void check_levels(input logic [RspDataWidth-1:0] data);
         pin_result_type want;
         if (levels_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: levels %h status %0d pin %0d",
                        data[31:0], data[33:32], data[41:34]);
            return;
         end
         want = levels_due.pop_front();
         if (data[31:0] !== want.pin_levels || data[33:32] !== want.status ||
             data[41:34] !== want.status_pin) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: expected levels %h status %0d pin %0d, got %h %0d %0d",
                        want.pin_levels, want.status, want.status_pin,
                        data[31:0], data[33:32], data[41:34]);
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;

   pin_bank     bank = new();
   int unsigned item_count = 0;
   int unsigned burst_left = 0;
   int unsigned hold_requests = 0;

   text_command_pin_driver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // Receiver: checks every transfer and stalls on its own changing pattern.
   int unsigned hold_left = 0;
   int unsigned holds_served = 0;
   int unsigned phase_left = 0;
   int unsigned ready_mode = 0;
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) bank.check_levels(rsp_tdata);
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left    = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            phase_left = $urandom_range(5, 80);
         end
         phase_left--;
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 0);
            2: rsp_tready <= ($urandom_range(0, 4) != 0);
            default: rsp_tready <= (phase_left % 8) < 3;
         endcase
      end
   end

   function automatic logic [WordWidth-1:0] pad_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic offer_item(input bit tick, input logic [CharWidth-1:0] ch, input bit last,
                             input logic [WordWidth-1:0] oe, input logic [WordWidth-1:0] pen,
                             input logic [WordWidth-1:0] psel);
      req_tvalid <= 1'b1;
      req_tuser  <= tick;
      req_tlast  <= last;
      req_tdata  <= {psel, pen, oe, ch};
      do @(posedge clock); while (!req_tready);
      bank.note_item(tick, ch, last, oe, pen, psel);
      item_count++;
   endtask

   task automatic idle_gap(input int unsigned cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // One item with random pad words, followed by burst pacing.
   task automatic send_random(input bit tick, input logic [CharWidth-1:0] ch, input bit last);
      offer_item(tick, ch, last, pad_word(), pad_word(), pad_word());
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 15);
      end
   endtask

   function automatic logic [CharWidth-1:0] non_digit();
      logic [CharWidth-1:0] ch;
      do ch = $urandom_range(0, 255); while (ch >= CHAR_ZERO && ch <= CHAR_NINE);
      return ch;
   endfunction

   // A well-formed pin command with random weak prefix, index and terminator.
   task automatic send_command();
      int unsigned          pin;
      string                digits;
      bit                   no_digits;
      bit                   end_chunk;
      logic [CharWidth-1:0] letter;
      int                   i;
      case ($urandom_range(0, 19))
         0, 1, 2: pin = $urandom_range(32, 300);
         3:       pin = $urandom_range(1000, 99999);
         default: pin = $urandom_range(0, PinCount - 1);
      endcase
      digits = $sformatf("%0d", pin);
      if ($urandom_range(0, 9) == 0) digits = {"0", digits};
      no_digits = ($urandom_range(0, 9) == 0);
      end_chunk = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
         0: letter = CHAR_L_LOWER;
         1: letter = CHAR_L_UPPER;
         2: letter = CHAR_H_LOWER;
         default: letter = CHAR_H_UPPER;
      endcase
      if ($urandom_range(0, 1) == 0)
         send_random(1'b0, ($urandom_range(0, 1) == 0) ? CHAR_W_LOWER : CHAR_W_UPPER, 1'b0);
      send_random(1'b0, letter, end_chunk && no_digits);
      if (!no_digits)
         for (i = 0; i < digits.len(); i++)
            send_random(1'b0, digits[i], end_chunk && i == digits.len() - 1);
      if (!end_chunk) send_random(1'b0, non_digit(), $urandom_range(0, 7) == 0);
   endtask

   initial begin
      bit drained;
      drained = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: ticks, weak mode, saturation, invalid index, letters inside a
      // number, chunk ends with and without digits, extreme pad words.
      offer_item(1'b1, 8'hff, 1'b1, '0, '0, '0);
      offer_item(1'b0, CHAR_W_LOWER, 1'b0, '1, '1, '0);
      offer_item(1'b0, CHAR_H_LOWER, 1'b0, '1, '1, '0);
      offer_item(1'b0, CHAR_ZERO + 8'd3, 1'b0, '1, '1, '0);
      offer_item(1'b0, CHAR_ZERO + 8'd1, 1'b0, '1, '1, '0);
      offer_item(1'b0, 8'h20, 1'b0, '1, '1, '0);
      offer_item(1'b1, 8'h00, 1'b0, '0, '1, '1);
      offer_item(1'b0, CHAR_H_UPPER, 1'b0, '1, '0, '1);
      offer_item(1'b0, CHAR_NINE, 1'b0, '1, '0, '1);
      offer_item(1'b0, CHAR_NINE, 1'b0, '1, '0, '1);
      offer_item(1'b0, CHAR_NINE, 1'b0, '1, '0, '1);
      offer_item(1'b0, 8'h78, 1'b0, '1, '0, '1);
      offer_item(1'b0, CHAR_L_UPPER, 1'b0, '0, '1, '1);
      offer_item(1'b0, CHAR_ZERO + 8'd3, 1'b0, '0, '1, '1);
      offer_item(1'b0, CHAR_ZERO + 8'd2, 1'b0, '0, '1, '1);
      offer_item(1'b0, CHAR_H_LOWER, 1'b0, '0, '1, '1);
      offer_item(1'b0, CHAR_L_LOWER, 1'b0, '0, '0, '0);
      offer_item(1'b0, CHAR_ZERO, 1'b1, '0, '0, '0);
      offer_item(1'b0, CHAR_H_LOWER, 1'b1, '1, '0, '0);
      offer_item(1'b0, CHAR_W_UPPER, 1'b1, '1, '1, '1);
      offer_item(1'b0, CHAR_L_LOWER, 1'b0, '1, '1, '1);
      offer_item(1'b0, CHAR_ZERO + 8'd7, 1'b0, '1, '1, '1);
      offer_item(1'b0, 8'h00, 1'b0, '1, '1, '1);
      offer_item(1'b0, CHAR_W_LOWER, 1'b0, '1, '1, '1);
      offer_item(1'b0, CHAR_H_LOWER, 1'b0, 32'h0000_0001, 32'h8000_0001, 32'h0000_0000);

      // Random: mostly well-formed commands, with noise characters and ticks.
      while (item_count < 1600) begin
         if (item_count >= 500 && hold_requests == 0) hold_requests <= 1;
         if (item_count >= 1000 && !drained) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (bank.pending() != 0);
            drained = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1:    send_random(1'b0, $urandom_range(0, 255), $urandom_range(0, 9) == 0);
            2:       send_random(1'b1, $urandom_range(0, 255), $urandom_range(0, 1));
            default: send_command();
         endcase
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (bank.pending() != 0);
      repeat (20) @(posedge clock);
      if (bank.mismatch_count == 0 && bank.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/tcpd_pkg.sv
hdl/tcpd_parse.sv
hdl/tcpd_resolve.sv
hdl/text_command_pin_driver.sv
test/tb_text_command_pin_driver.sv
